FILE: rtl/core/ptrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_pkg
// Shared constants and types for the periodic task release scheduler.
// ----------------------------------------------------------------------------
package ptrs_pkg;

   // slot table size
   localparam int NUM_SLOTS = 8;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   // field widths
   localparam int KIND_W   = 3;
   localparam int DATA_W   = 8;
   localparam int STATUS_W = 2;
   localparam int MASK_W   = 8;
   localparam int ENTRY_W  = 2 * DATA_W;

   // command codes
   localparam logic [KIND_W-1:0] KIND_TICK    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_CREATE  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_DELETE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUSPEND = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RESUME  = 3'd4;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_SLOT = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

   // modulo unit request and response
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } mod_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic zero;
   } mod_rsp_type;

endpackage

FILE: rtl/core/periodic_task_release_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_task_release_scheduler_unit
// Slot table scheduler: period and phase in a RAM, flags in flops.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken on a rising edge with start high and busy low.
//   Kinds are tick, create, delete, suspend and resume. Every command gives
//   exactly one response beat, flagged by rsp_strobe for a single cycle,
//   carrying rsp_run_mask (tick only) and rsp_status.
//   Create, delete, suspend, resume and unused kinds respond on the cycle
//   after the command; busy stays low, so a command may follow every cycle.
//   A tick walks the slots in turn. A slot that is not valid and active
//   goes from its scan state straight on to the next slot. A valid,
//   active slot goes from its scan state to a RAM read state, then through
//   two passes of the shared remainder unit (eight steps and a done flag
//   each). busy is high during the walk and falls as its response appears.
//   Reset clears the tick counter and all slot flags; the period and phase
//   RAM is not cleared, as only created slots are ever read.
//   The receiver cannot stall: each response beat is taken as it appears.
// ----------------------------------------------------------------------------
module periodic_task_release_scheduler_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ptrs_pkg::KIND_W-1:0]     req_kind,
   input  logic [ptrs_pkg::DATA_W-1:0]     req_slot,
   input  logic [ptrs_pkg::DATA_W-1:0]     req_period,
   input  logic [ptrs_pkg::DATA_W-1:0]     req_first_delay,
   input  logic                            req_start_active,
   output logic                            rsp_strobe,
   output logic [ptrs_pkg::MASK_W-1:0]     rsp_run_mask,
   output logic [ptrs_pkg::STATUS_W-1:0]   rsp_status
);

   localparam int NS = ptrs_pkg::NUM_SLOTS;
   localparam int SW = ptrs_pkg::SLOT_W;
   localparam int DW = ptrs_pkg::DATA_W;
   localparam int MW = ptrs_pkg::MASK_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_LOAD,
      S_MOD1,
      S_MOD2
   } state_type;

   state_type                    state_ff, state_in;
   logic [DW-1:0]                tick_ff, tick_in;
   logic [NS-1:0]                valid_ff, valid_in;
   logic [NS-1:0]                active_ff, active_in;
   logic [NS-1:0]                first_ff, first_in;
   logic [SW-1:0]                idx_ff, idx_in;
   logic [MW-1:0]                mask_ff, mask_in;
   logic [DW-1:0]                per_ff, per_in;
   logic [DW-1:0]                since_ff, since_in;
   logic                         chk1_ff, chk1_in;
   logic                         fire1_ff, fire1_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   logic [MW-1:0]                rsp_run_mask_ff, rsp_run_mask_in;
   logic [ptrs_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                         ram_wr_en;
   logic                         ram_rd_en;
   logic [ptrs_pkg::ENTRY_W-1:0] ram_rd_data;
   ptrs_pkg::mod_req_type        mod_req;
   ptrs_pkg::mod_rsp_type        mod_rsp;

   logic [SW-1:0]                sel;
   logic                         in_range;
   logic [DW-1:0]                rd_phase;

   assign sel      = req_slot[SW-1:0];
   assign in_range = (req_slot < DW'(NS));
   assign rd_phase = ram_rd_data[DW-1:0];

   // period and phase table; writes happen only when idle and reads only
   // during a tick walk, so the two never touch the same entry at once
   ptrs_ram #(
      .WIDTH (ptrs_pkg::ENTRY_W),
      .DEPTH (NS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (sel),
      .wr_data ({req_period, req_first_delay}),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   // shared remainder unit
   ptrs_mod u_mod (
      .clock (clock),
      .reset (reset),
      .req   (mod_req),
      .rsp   (mod_rsp)
   );

   // sequencer next state
   always_comb begin
      logic          fire;
      logic [MW-1:0] mask_next;
      logic          advance;

      fire            = 1'b0;
      mask_next       = mask_ff;
      advance         = 1'b0;
      state_in        = state_ff;
      tick_in         = tick_ff;
      valid_in        = valid_ff;
      active_in       = active_ff;
      first_in        = first_ff;
      idx_in          = idx_ff;
      mask_in         = mask_ff;
      per_in          = per_ff;
      since_in        = since_ff;
      chk1_in         = chk1_ff;
      fire1_in        = fire1_ff;
      rsp_strobe_in   = 1'b0;
      rsp_run_mask_in = rsp_run_mask_ff;
      rsp_status_in   = rsp_status_ff;
      ram_wr_en       = 1'b0;
      ram_rd_en       = 1'b0;
      mod_req.start    = 1'b0;
      mod_req.dividend = tick_ff;
      mod_req.divisor  = rd_phase;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               rsp_strobe_in   = 1'b1;
               rsp_run_mask_in = '0;
               rsp_status_in   = ptrs_pkg::ST_OK;
               unique case (req_kind) inside
                  ptrs_pkg::KIND_TICK: begin
                     rsp_strobe_in = 1'b0;
                     tick_in       = tick_ff + 1'b1;
                     idx_in        = '0;
                     mask_in       = '0;
                     state_in      = S_SCAN;
                  end
                  ptrs_pkg::KIND_CREATE: begin
                     if (!in_range || valid_ff[sel]) begin
                        rsp_status_in = ptrs_pkg::ST_SLOT;
                     end else if (req_period == '0 || req_first_delay == '0) begin
                        rsp_status_in = ptrs_pkg::ST_ZERO;
                     end else begin
                        valid_in[sel]  = 1'b1;
                        active_in[sel] = req_start_active;
                        first_in[sel]  = 1'b1;
                        ram_wr_en      = 1'b1;
                     end
                  end
                  ptrs_pkg::KIND_DELETE: begin
                     if (!in_range) begin
                        rsp_status_in = ptrs_pkg::ST_SLOT;
                     end else begin
                        valid_in[sel] = 1'b0;
                     end
                  end
                  ptrs_pkg::KIND_SUSPEND, ptrs_pkg::KIND_RESUME: begin
                     if (!in_range) begin
                        rsp_status_in = ptrs_pkg::ST_SLOT;
                     end else begin
                        active_in[sel] = (req_kind == ptrs_pkg::KIND_RESUME);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (valid_ff[idx_ff] && active_ff[idx_ff]) begin
               ram_rd_en = 1'b1;
               state_in  = S_LOAD;
            end else begin
               advance = 1'b1;
            end
         end
         S_LOAD: begin
            // entry arrives; first pass is tick mod phase
            per_in          = ram_rd_data[2*DW-1:DW];
            since_in        = tick_ff - rd_phase;
            chk1_in         = first_ff[idx_ff] && (rd_phase != '0);
            mod_req.start    = 1'b1;
            mod_req.dividend = tick_ff;
            mod_req.divisor  = rd_phase;
            state_in        = S_MOD1;
         end
         S_MOD1: begin
            if (mod_rsp.done) begin
               fire1_in = chk1_ff && mod_rsp.zero;
               if (chk1_ff && mod_rsp.zero) begin
                  first_in[idx_ff] = 1'b0;
               end
               // second pass is (tick - phase) mod period
               mod_req.start    = 1'b1;
               mod_req.dividend = since_ff;
               mod_req.divisor  = per_ff;
               state_in        = S_MOD2;
            end
         end
         S_MOD2: begin
            if (mod_rsp.done) begin
               fire = fire1_ff || ((per_ff != '0) && mod_rsp.zero);
               if (fire) begin
                  mask_next = mask_ff | (MW'(1) << idx_ff);
               end
               mask_in = mask_next;
               advance = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // step to the next slot or finish the walk
      if (advance) begin
         if (idx_ff == SW'(NS - 1)) begin
            rsp_strobe_in   = 1'b1;
            rsp_run_mask_in = mask_next;
            rsp_status_in   = ptrs_pkg::ST_OK;
            state_in        = S_IDLE;
         end else begin
            idx_in   = idx_ff + 1'b1;
            state_in = S_SCAN;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tick_ff       <= '0;
         valid_ff      <= '0;
         active_ff     <= '0;
         first_ff      <= '0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_ff       <= tick_in;
         valid_ff      <= valid_in;
         active_ff     <= active_in;
         first_ff      <= first_in;
         idx_ff        <= idx_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      mask_ff         <= mask_in;
      per_ff          <= per_in;
      since_ff        <= since_in;
      chk1_ff         <= chk1_in;
      fire1_ff        <= fire1_in;
      rsp_run_mask_ff <= rsp_run_mask_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_strobe   = rsp_strobe_ff;
   assign rsp_run_mask = rsp_run_mask_ff;
   assign rsp_status   = rsp_status_ff;

   // a command other than tick answers on the next cycle
   a_cmd_resp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind != ptrs_pkg::KIND_TICK) |=> rsp_strobe)
      else $error("command beat without response on next cycle");

   // a tick starts a walk and does not answer at once
   a_tick_walk: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_kind == ptrs_pkg::KIND_TICK) |=> (busy && !rsp_strobe))
      else $error("tick beat did not start a slot walk");

   // remainder unit is never restarted mid-run
   a_mod_free: assert property (@(posedge clock) disable iff (reset)
      mod_req.start |-> !mod_rsp.busy)
      else $error("remainder unit started while running");

   // a release mask only comes with an ok status
   a_mask_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_run_mask != '0) |-> (rsp_status == ptrs_pkg::ST_OK))
      else $error("release mask with error status");

endmodule

FILE: rtl/core/ptrs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ptrs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 8
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/ptrs_mod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrs_mod
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module ptrs_mod (
   input  logic                  clock,
   input  logic                  reset,
   input  ptrs_pkg::mod_req_type req,
   output ptrs_pkg::mod_rsp_type rsp
);

   localparam int DW    = ptrs_pkg::DATA_W;
   localparam int CNT_W = (DW > 1) ? $clog2(DW) : 1;

   logic [DW-1:0]    dvd_ff, dvd_in;
   logic [DW-1:0]    div_ff, div_in;
   logic [DW-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [DW:0]      trial;
   logic [DW:0]      diff;

   // one restoring step per cycle
   always_comb begin
      trial   = {rem_ff, dvd_ff[DW-1]};
      diff    = trial - {1'b0, div_ff};
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         dvd_in = req.dividend;
         div_in = req.divisor;
         rem_in = '0;
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = (trial >= {1'b0, div_ff}) ? diff[DW-1:0] : trial[DW-1:0];
         dvd_in = {dvd_ff[DW-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign rsp.busy = run_ff;
   assign rsp.done = done_ff;
   assign rsp.zero = (rem_ff == '0);

endmodule
